### src/m6502_pd_pkg.sv
// Package for the 6502 instruction predecoder: mnemonic and mode codes,
// the record type and the documented-opcode decode table.
// No dependencies.
`default_nettype none

package m6502_pd_pkg;

   // Configuration register indexes and widths
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_LIMIT    = 2'd1;

   localparam logic [16:0] BYTE_LIMIT_RESET    = 17'd256;
   localparam logic [15:0] START_ADDRESS_RESET = 16'd0;

   // Dense mnemonic numbers in table order; MNE_DATA marks a data byte
   typedef enum logic [5:0] {
      MNE_AND, MNE_EOR, MNE_ORA, MNE_ASL, MNE_LSR, MNE_ROL, MNE_ROR,
      MNE_BPL, MNE_BMI, MNE_BVC, MNE_BVS, MNE_BCC, MNE_BCS, MNE_BNE, MNE_BEQ,
      MNE_CMP, MNE_CPX, MNE_CPY, MNE_BIT, MNE_CLC, MNE_SEC, MNE_CLI, MNE_SEI,
      MNE_CLD, MNE_SED, MNE_CLV, MNE_JMP, MNE_JSR, MNE_RTS, MNE_RTI, MNE_ADC,
      MNE_SBC, MNE_LDA, MNE_LDX, MNE_LDY, MNE_STA, MNE_STX, MNE_STY, MNE_DEC,
      MNE_INC, MNE_TAX, MNE_TAY, MNE_TXA, MNE_TYA, MNE_DEX, MNE_DEY, MNE_INX,
      MNE_INY, MNE_PHA, MNE_PHP, MNE_TXS, MNE_PLA, MNE_TSX, MNE_PLP, MNE_BRK,
      MNE_NOP, MNE_DATA
   } mne_type;

   // Addressing modes; MODE_NONE marks a data byte
   typedef enum logic [3:0] {
      MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_ABS, MODE_ABSX, MODE_ABSY,
      MODE_INDX, MODE_INDY, MODE_ACC, MODE_IMPL, MODE_REL, MODE_IND, MODE_NONE
   } mode_type;

   typedef struct packed {
      logic       known;
      mne_type    mne;
      mode_type   mode;
      logic [1:0] len;
   } dec_type;

   typedef struct packed {
      logic [15:0] instr_address;
      logic [7:0]  opcode_byte;
      logic [5:0]  mnemonic_id;
      logic [3:0]  mode_id;
      logic [1:0]  instr_length;
      logic [15:0] operand_value;
      logic        is_data;
      logic        truncated;
   } rec_type;

   // Instruction length implied by the addressing mode
   function automatic logic [1:0] mode_len(input mode_type mode);
      logic [1:0] len;
      unique case (mode)
         MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: len = 2'd3;
         MODE_ACC, MODE_IMPL, MODE_NONE:           len = 2'd1;
         default:                                  len = 2'd2;
      endcase
      return len;
   endfunction

   function automatic dec_type mk(input mne_type mne, input mode_type mode);
      dec_type d;
      d.known = 1'b1;
      d.mne   = mne;
      d.mode  = mode;
      d.len   = mode_len(mode);
      return d;
   endfunction

   // Documented opcode table
   function automatic dec_type decode(input logic [7:0] op);
      dec_type d;
      d.known = 1'b0;
      d.mne   = MNE_DATA;
      d.mode  = MODE_NONE;
      d.len   = 2'd1;
      unique case (op)
         8'h29: d = mk(MNE_AND, MODE_IMM);  8'h25: d = mk(MNE_AND, MODE_ZP);
         8'h35: d = mk(MNE_AND, MODE_ZPX);  8'h2D: d = mk(MNE_AND, MODE_ABS);
         8'h3D: d = mk(MNE_AND, MODE_ABSX); 8'h39: d = mk(MNE_AND, MODE_ABSY);
         8'h21: d = mk(MNE_AND, MODE_INDX); 8'h31: d = mk(MNE_AND, MODE_INDY);
         8'h49: d = mk(MNE_EOR, MODE_IMM);  8'h45: d = mk(MNE_EOR, MODE_ZP);
         8'h55: d = mk(MNE_EOR, MODE_ZPX);  8'h4D: d = mk(MNE_EOR, MODE_ABS);
         8'h5D: d = mk(MNE_EOR, MODE_ABSX); 8'h59: d = mk(MNE_EOR, MODE_ABSY);
         8'h41: d = mk(MNE_EOR, MODE_INDX); 8'h51: d = mk(MNE_EOR, MODE_INDY);
         8'h09: d = mk(MNE_ORA, MODE_IMM);  8'h05: d = mk(MNE_ORA, MODE_ZP);
         8'h15: d = mk(MNE_ORA, MODE_ZPX);  8'h0D: d = mk(MNE_ORA, MODE_ABS);
         8'h1D: d = mk(MNE_ORA, MODE_ABSX); 8'h19: d = mk(MNE_ORA, MODE_ABSY);
         8'h01: d = mk(MNE_ORA, MODE_INDX); 8'h11: d = mk(MNE_ORA, MODE_INDY);
         8'h0A: d = mk(MNE_ASL, MODE_ACC);  8'h06: d = mk(MNE_ASL, MODE_ZP);
         8'h16: d = mk(MNE_ASL, MODE_ZPX);  8'h0E: d = mk(MNE_ASL, MODE_ABS);
         8'h1E: d = mk(MNE_ASL, MODE_ABSX);
         8'h4A: d = mk(MNE_LSR, MODE_ACC);  8'h46: d = mk(MNE_LSR, MODE_ZP);
         8'h56: d = mk(MNE_LSR, MODE_ZPX);  8'h4E: d = mk(MNE_LSR, MODE_ABS);
         8'h5E: d = mk(MNE_LSR, MODE_ABSX);
         8'h2A: d = mk(MNE_ROL, MODE_ACC);  8'h26: d = mk(MNE_ROL, MODE_ZP);
         8'h36: d = mk(MNE_ROL, MODE_ZPX);  8'h2E: d = mk(MNE_ROL, MODE_ABS);
         8'h3E: d = mk(MNE_ROL, MODE_ABSX);
         8'h6A: d = mk(MNE_ROR, MODE_ACC);  8'h66: d = mk(MNE_ROR, MODE_ZP);
         8'h76: d = mk(MNE_ROR, MODE_ZPX);  8'h6E: d = mk(MNE_ROR, MODE_ABS);
         8'h7E: d = mk(MNE_ROR, MODE_ABSX);
         8'h10: d = mk(MNE_BPL, MODE_REL);  8'h30: d = mk(MNE_BMI, MODE_REL);
         8'h50: d = mk(MNE_BVC, MODE_REL);  8'h70: d = mk(MNE_BVS, MODE_REL);
         8'h90: d = mk(MNE_BCC, MODE_REL);  8'hB0: d = mk(MNE_BCS, MODE_REL);
         8'hD0: d = mk(MNE_BNE, MODE_REL);  8'hF0: d = mk(MNE_BEQ, MODE_REL);
         8'hC9: d = mk(MNE_CMP, MODE_IMM);  8'hC5: d = mk(MNE_CMP, MODE_ZP);
         8'hD5: d = mk(MNE_CMP, MODE_ZPX);  8'hCD: d = mk(MNE_CMP, MODE_ABS);
         8'hDD: d = mk(MNE_CMP, MODE_ABSX); 8'hD9: d = mk(MNE_CMP, MODE_ABSY);
         8'hC1: d = mk(MNE_CMP, MODE_INDX); 8'hD1: d = mk(MNE_CMP, MODE_INDY);
         8'hE0: d = mk(MNE_CPX, MODE_IMM);  8'hE4: d = mk(MNE_CPX, MODE_ZP);
         8'hEC: d = mk(MNE_CPX, MODE_ABS);
         8'hC0: d = mk(MNE_CPY, MODE_IMM);  8'hC4: d = mk(MNE_CPY, MODE_ZP);
         8'hCC: d = mk(MNE_CPY, MODE_ABS);
         8'h24: d = mk(MNE_BIT, MODE_ZP);   8'h2C: d = mk(MNE_BIT, MODE_ABS);
         8'h18: d = mk(MNE_CLC, MODE_IMPL); 8'h38: d = mk(MNE_SEC, MODE_IMPL);
         8'h58: d = mk(MNE_CLI, MODE_IMPL); 8'h78: d = mk(MNE_SEI, MODE_IMPL);
         8'hD8: d = mk(MNE_CLD, MODE_IMPL); 8'hF8: d = mk(MNE_SED, MODE_IMPL);
         8'hB8: d = mk(MNE_CLV, MODE_IMPL);
         8'h4C: d = mk(MNE_JMP, MODE_ABS);  8'h6C: d = mk(MNE_JMP, MODE_IND);
         8'h20: d = mk(MNE_JSR, MODE_ABS);  8'h60: d = mk(MNE_RTS, MODE_IMPL);
         8'h40: d = mk(MNE_RTI, MODE_IMPL);
         8'h69: d = mk(MNE_ADC, MODE_IMM);  8'h65: d = mk(MNE_ADC, MODE_ZP);
         8'h75: d = mk(MNE_ADC, MODE_ZPX);  8'h6D: d = mk(MNE_ADC, MODE_ABS);
         8'h7D: d = mk(MNE_ADC, MODE_ABSX); 8'h79: d = mk(MNE_ADC, MODE_ABSY);
         8'h61: d = mk(MNE_ADC, MODE_INDX); 8'h71: d = mk(MNE_ADC, MODE_INDY);
         8'hE9: d = mk(MNE_SBC, MODE_IMM);  8'hE5: d = mk(MNE_SBC, MODE_ZP);
         8'hF5: d = mk(MNE_SBC, MODE_ZPX);  8'hED: d = mk(MNE_SBC, MODE_ABS);
         8'hFD: d = mk(MNE_SBC, MODE_ABSX); 8'hF9: d = mk(MNE_SBC, MODE_ABSY);
         8'hE1: d = mk(MNE_SBC, MODE_INDX); 8'hF1: d = mk(MNE_SBC, MODE_INDY);
         8'hA9: d = mk(MNE_LDA, MODE_IMM);  8'hA5: d = mk(MNE_LDA, MODE_ZP);
         8'hB5: d = mk(MNE_LDA, MODE_ZPX);  8'hAD: d = mk(MNE_LDA, MODE_ABS);
         8'hBD: d = mk(MNE_LDA, MODE_ABSX); 8'hB9: d = mk(MNE_LDA, MODE_ABSY);
         8'hA1: d = mk(MNE_LDA, MODE_INDX); 8'hB1: d = mk(MNE_LDA, MODE_INDY);
         8'hA2: d = mk(MNE_LDX, MODE_IMM);  8'hA6: d = mk(MNE_LDX, MODE_ZP);
         8'hB6: d = mk(MNE_LDX, MODE_ZPY);  8'hAE: d = mk(MNE_LDX, MODE_ABS);
         8'hBE: d = mk(MNE_LDX, MODE_ABSY);
         8'hA0: d = mk(MNE_LDY, MODE_IMM);  8'hA4: d = mk(MNE_LDY, MODE_ZP);
         8'hB4: d = mk(MNE_LDY, MODE_ZPX);  8'hAC: d = mk(MNE_LDY, MODE_ABS);
         8'hBC: d = mk(MNE_LDY, MODE_ABSX);
         8'h85: d = mk(MNE_STA, MODE_ZP);   8'h95: d = mk(MNE_STA, MODE_ZPX);
         8'h8D: d = mk(MNE_STA, MODE_ABS);  8'h9D: d = mk(MNE_STA, MODE_ABSX);
         8'h99: d = mk(MNE_STA, MODE_ABSY); 8'h81: d = mk(MNE_STA, MODE_INDX);
         8'h91: d = mk(MNE_STA, MODE_INDY);
         8'h86: d = mk(MNE_STX, MODE_ZP);   8'h96: d = mk(MNE_STX, MODE_ZPY);
         8'h8E: d = mk(MNE_STX, MODE_ABS);
         8'h84: d = mk(MNE_STY, MODE_ZP);   8'h94: d = mk(MNE_STY, MODE_ZPX);
         8'h8C: d = mk(MNE_STY, MODE_ABS);
         8'hC6: d = mk(MNE_DEC, MODE_ZP);   8'hD6: d = mk(MNE_DEC, MODE_ZPX);
         8'hCE: d = mk(MNE_DEC, MODE_ABS);  8'hDE: d = mk(MNE_DEC, MODE_ABSX);
         8'hE6: d = mk(MNE_INC, MODE_ZP);   8'hF6: d = mk(MNE_INC, MODE_ZPX);
         8'hEE: d = mk(MNE_INC, MODE_ABS);  8'hFE: d = mk(MNE_INC, MODE_ABSX);
         8'hAA: d = mk(MNE_TAX, MODE_IMPL); 8'hA8: d = mk(MNE_TAY, MODE_IMPL);
         8'h8A: d = mk(MNE_TXA, MODE_IMPL); 8'h98: d = mk(MNE_TYA, MODE_IMPL);
         8'hCA: d = mk(MNE_DEX, MODE_IMPL); 8'h88: d = mk(MNE_DEY, MODE_IMPL);
         8'hE8: d = mk(MNE_INX, MODE_IMPL); 8'hC8: d = mk(MNE_INY, MODE_IMPL);
         8'h48: d = mk(MNE_PHA, MODE_IMPL); 8'h08: d = mk(MNE_PHP, MODE_IMPL);
         8'h9A: d = mk(MNE_TXS, MODE_IMPL); 8'h68: d = mk(MNE_PLA, MODE_IMPL);
         8'hBA: d = mk(MNE_TSX, MODE_IMPL); 8'h28: d = mk(MNE_PLP, MODE_IMPL);
         8'h00: d = mk(MNE_BRK, MODE_IMPL); 8'hEA: d = mk(MNE_NOP, MODE_IMPL);
         default: ;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### src/m6502_pd_if.sv
// Handshake channels of the 6502 instruction predecoder: byte input,
// record output and register write port. Depends on m6502_pd_pkg.
`default_nettype none

interface m6502_pd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last_byte;
   modport source (output valid, output code_byte, output last_byte, input ready);
   modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

interface m6502_pd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] instr_address;
   logic [7:0]  opcode_byte;
   logic [5:0]  mnemonic_id;
   logic [3:0]  mode_id;
   logic [1:0]  instr_length;
   logic [15:0] operand_value;
   logic        is_data;
   logic        truncated;
   modport source (output valid, output instr_address, output opcode_byte,
                   output mnemonic_id, output mode_id, output instr_length,
                   output operand_value, output is_data, output truncated,
                   input ready);
   modport sink   (input valid, input instr_address, input opcode_byte,
                   input mnemonic_id, input mode_id, input instr_length,
                   input operand_value, input is_data, input truncated,
                   output ready);
endinterface

interface m6502_pd_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [m6502_pd_pkg::CSR_IDX_W-1:0]       reg_index;
   logic [m6502_pd_pkg::CSR_DATA_W-1:0]      wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

### src/mos6502_instruction_predecoder_top.sv
// Top level of the 6502 instruction predecoder: frames a byte stream into
// instruction records. Depends on m6502_pd_pkg and m6502_pd_if.
//
//   channel   dir  word                               handshake
//   req_bus   in   code_byte, last_byte                valid/ready
//   rsp_bus   out  one instruction or data record      valid/ready
//   csr_bus   in   reg_index, wr_data                  valid/ready, always ready
//
// One byte is accepted per cycle while the output is not stalled; its record,
// if any, appears in the output register on the next cycle. The opcode table
// lookup and the framing counter are combinational logic between the input
// port and the output register. Reset (synchronous) clears framing state and
// loads register defaults. A stalled output holds its record; input is taken
// whenever the output register is empty or being emptied in the same cycle.
`default_nettype none

module mos6502_instruction_predecoder_top (
   input  wire                 clock,
   input  wire                 reset,
   m6502_pd_req_if.sink        req_bus,
   m6502_pd_rsp_if.source      rsp_bus,
   m6502_pd_csr_if.sink        csr_bus
);

   // Configuration registers
   logic [15:0] start_address_ff;
   logic [16:0] byte_limit_ff;

   // Framing state
   logic [1:0]  bytes_pending_ff, bytes_pending_in;
   logic [16:0] bytes_seen_ff, bytes_seen_in;
   logic [15:0] byte_address_ff, byte_address_in;
   logic [7:0]  operand_low_ff, operand_low_in;
   logic [7:0]  held_opcode_ff, held_opcode_in;
   logic [15:0] held_address_ff, held_address_in;
   m6502_pd_pkg::dec_type held_dec_ff, held_dec_in;

   // Output register
   logic                  rsp_valid_ff;
   m6502_pd_pkg::rec_type rsp_rec_ff, rsp_rec_in;
   logic                  emit;

   logic                  accept;
   logic                  past_limit;
   logic [15:0]           cur_addr;
   logic [16:0]           seen_inc;
   logic                  stream_end;
   m6502_pd_pkg::dec_type dec;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign past_limit = bytes_seen_ff >= byte_limit_ff;
   assign cur_addr   = (bytes_seen_ff == 17'd0) ? start_address_ff : byte_address_ff;
   assign seen_inc   = bytes_seen_ff + 17'd1;
   assign stream_end = req_bus.last_byte || (seen_inc == byte_limit_ff);
   assign dec        = m6502_pd_pkg::decode(req_bus.code_byte);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= m6502_pd_pkg::START_ADDRESS_RESET;
         byte_limit_ff    <= m6502_pd_pkg::BYTE_LIMIT_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.reg_index)
            m6502_pd_pkg::CSR_START_ADDRESS: start_address_ff <= csr_bus.wr_data[15:0];
            m6502_pd_pkg::CSR_BYTE_LIMIT:    byte_limit_ff    <= csr_bus.wr_data;
            default: ;
         endcase
      end
   end

   // Frame the incoming byte and build its record
   always_comb begin
      bytes_pending_in = bytes_pending_ff;
      bytes_seen_in    = bytes_seen_ff;
      byte_address_in  = byte_address_ff;
      operand_low_in   = operand_low_ff;
      held_opcode_in   = held_opcode_ff;
      held_address_in  = held_address_ff;
      held_dec_in      = held_dec_ff;
      emit             = 1'b0;
      // default record: the held instruction, flagged truncated
      rsp_rec_in.instr_address = held_address_ff;
      rsp_rec_in.opcode_byte   = held_opcode_ff;
      rsp_rec_in.mnemonic_id   = held_dec_ff.mne;
      rsp_rec_in.mode_id       = held_dec_ff.mode;
      rsp_rec_in.instr_length  = held_dec_ff.len;
      rsp_rec_in.operand_value = 16'd0;
      rsp_rec_in.is_data       = 1'b0;
      rsp_rec_in.truncated     = 1'b1;

      if (accept) begin
         if (past_limit) begin
            // past the limit: only a final byte matters, flushing what is held
            if (req_bus.last_byte) begin
               if (bytes_pending_ff != 2'd0) begin
                  emit = 1'b1;
                  if (bytes_pending_ff == 2'd1) begin
                     rsp_rec_in.operand_value = {8'd0, operand_low_ff};
                  end
               end
               bytes_pending_in = 2'd0;
               bytes_seen_in    = 17'd0;
            end
         end else begin
            bytes_seen_in   = seen_inc;
            byte_address_in = cur_addr + 16'd1;
            unique case (bytes_pending_ff)
               2'd2: begin
                  // first operand byte
                  operand_low_in   = req_bus.code_byte;
                  bytes_pending_in = 2'd1;
                  if (stream_end) begin
                     emit                     = 1'b1;
                     rsp_rec_in.operand_value = {8'd0, req_bus.code_byte};
                     bytes_pending_in         = 2'd0;
                  end
               end
               2'd1: begin
                  // final operand byte completes the instruction
                  emit                 = 1'b1;
                  rsp_rec_in.truncated = 1'b0;
                  if (held_dec_ff.len == 2'd3) begin
                     rsp_rec_in.operand_value = {req_bus.code_byte, operand_low_ff};
                  end else begin
                     rsp_rec_in.operand_value = {8'd0, req_bus.code_byte};
                  end
                  bytes_pending_in = 2'd0;
               end
               default: begin
                  // opcode position
                  bytes_pending_in         = 2'd0;
                  rsp_rec_in.instr_address = cur_addr;
                  rsp_rec_in.opcode_byte   = req_bus.code_byte;
                  rsp_rec_in.mnemonic_id   = dec.mne;
                  rsp_rec_in.mode_id       = dec.mode;
                  rsp_rec_in.instr_length  = dec.len;
                  rsp_rec_in.is_data       = !dec.known;
                  if (!dec.known || dec.len == 2'd1) begin
                     emit                 = 1'b1;
                     rsp_rec_in.truncated = 1'b0;
                  end else begin
                     held_opcode_in   = req_bus.code_byte;
                     held_address_in  = cur_addr;
                     held_dec_in      = dec;
                     operand_low_in   = 8'd0;
                     bytes_pending_in = dec.len - 2'd1;
                     if (stream_end) begin
                        emit             = 1'b1;
                        bytes_pending_in = 2'd0;
                     end
                  end
               end
            endcase
            if (req_bus.last_byte) begin
               bytes_pending_in = 2'd0;
               bytes_seen_in    = 17'd0;
            end
         end
      end
   end

   // Advance framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff <= 2'd0;
         bytes_seen_ff    <= 17'd0;
         byte_address_ff  <= m6502_pd_pkg::START_ADDRESS_RESET;
         operand_low_ff   <= 8'd0;
         held_opcode_ff   <= 8'd0;
         held_address_ff  <= 16'd0;
         held_dec_ff      <= m6502_pd_pkg::decode(8'd0);
      end else begin
         bytes_pending_ff <= bytes_pending_in;
         bytes_seen_ff    <= bytes_seen_in;
         byte_address_ff  <= byte_address_in;
         operand_low_ff   <= operand_low_in;
         held_opcode_ff   <= held_opcode_in;
         held_address_ff  <= held_address_in;
         held_dec_ff      <= held_dec_in;
      end
   end

   // Hold the record until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_rec_ff <= rsp_rec_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.instr_address = rsp_rec_ff.instr_address;
   assign rsp_bus.opcode_byte   = rsp_rec_ff.opcode_byte;
   assign rsp_bus.mnemonic_id   = rsp_rec_ff.mnemonic_id;
   assign rsp_bus.mode_id       = rsp_rec_ff.mode_id;
   assign rsp_bus.instr_length  = rsp_rec_ff.instr_length;
   assign rsp_bus.operand_value = rsp_rec_ff.operand_value;
   assign rsp_bus.is_data       = rsp_rec_ff.is_data;
   assign rsp_bus.truncated     = rsp_rec_ff.truncated;

endmodule

`default_nettype wire

### src/m6502_pd_checker.sv
// Port-level checks for the 6502 instruction predecoder, bound to the top
// level. Depends on m6502_pd_pkg and mos6502_instruction_predecoder_top.
`default_nettype none

module m6502_pd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [15:0] rsp_instr_address,
   input wire [7:0]  rsp_opcode_byte,
   input wire [5:0]  rsp_mnemonic_id,
   input wire [3:0]  rsp_mode_id,
   input wire [1:0]  rsp_instr_length,
   input wire [15:0] rsp_operand_value,
   input wire        rsp_is_data,
   input wire        rsp_truncated
);

   // A stalled word stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // A stalled word keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_instr_address) && $stable(rsp_opcode_byte)
         && $stable(rsp_operand_value) && $stable(rsp_truncated))
      else $error("rsp payload changed while stalled");

   // An empty output register never blocks input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output register");

   // Data records carry fixed fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_data |->
         rsp_mnemonic_id == m6502_pd_pkg::MNE_DATA
         && rsp_mode_id == m6502_pd_pkg::MODE_NONE
         && rsp_instr_length == 2'd1 && rsp_operand_value == 16'd0 && !rsp_truncated)
      else $error("malformed data record");

   // A truncated record is a multi-byte instruction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> !rsp_is_data && rsp_instr_length != 2'd1
         && rsp_instr_length != 2'd0)
      else $error("truncated record with bad length");

endmodule

bind mos6502_instruction_predecoder_top m6502_pd_checker u_m6502_pd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_instr_address (rsp_bus.instr_address),
   .rsp_opcode_byte   (rsp_bus.opcode_byte),
   .rsp_mnemonic_id   (rsp_bus.mnemonic_id),
   .rsp_mode_id       (rsp_bus.mode_id),
   .rsp_instr_length  (rsp_bus.instr_length),
   .rsp_operand_value (rsp_bus.operand_value),
   .rsp_is_data       (rsp_bus.is_data),
   .rsp_truncated     (rsp_bus.truncated)
);

`default_nettype wire
